// ----- hdl/x86alu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_pkg
// Shared types and codes for the register-form x86 ALU block.
// ----------------------------------------------------------------------------
package x86alu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NREGS    = 8;
  localparam int unsigned RIDX_W   = 3;
  localparam int unsigned FUNC_W   = 4;
  localparam int unsigned CNT_W    = 5;

  // operation codes carried in the func field
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CMP_RR   = 4'd0,
    FUNC_TEST_R8  = 4'd1,
    FUNC_SUB_I32  = 4'd2,
    FUNC_SHIFT    = 4'd3,
    FUNC_OR_EAX   = 4'd4,
    FUNC_OR_R8_I8 = 4'd5,
    FUNC_OR_I32   = 4'd6,
    FUNC_ADD_I8   = 4'd7,
    FUNC_SUB_I8   = 4'd8,
    FUNC_CMP_I8   = 4'd9,
    FUNC_ADD_RR   = 4'd10,
    FUNC_SUB_RR   = 4'd11
  } func_e;

  // shift group subops in the reg field of modrm
  typedef enum logic [2:0] {
    SH_ROL = 3'd0,
    SH_ROR = 3'd1,
    SH_RCL = 3'd2,
    SH_RCR = 3'd3,
    SH_SHL = 3'd4,
    SH_SHR = 3'd5,
    SH_SAL = 3'd6,
    SH_SAR = 3'd7
  } shift_op_e;

  typedef struct packed {
    logic cf;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  // outcome of one item, handed from execute to the commit logic
  typedef struct packed {
    logic              wr;
    logic [RIDX_W-1:0] dst;
    logic [XLEN-1:0]   value;
    flags_t            flags;
  } exec_res_t;

endpackage

// ----- hdl/x86alu_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_regs
// Eight-entry register file: one write port, two read ports with registered
// read data and write-to-read bypass. Entries read as zero until written.
// ----------------------------------------------------------------------------
module x86alu_regs
  import x86alu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [RIDX_W-1:0] ra_addr_i,
  input  logic [RIDX_W-1:0] rb_addr_i,
  input  logic              we_i,
  input  logic [RIDX_W-1:0] waddr_i,
  input  logic [XLEN-1:0]   wdata_i,
  output logic [XLEN-1:0]   ra_data_o,
  output logic [XLEN-1:0]   rb_data_o
);

  logic [XLEN-1:0]  mem [NREGS];
  logic [NREGS-1:0] valid_q;
  logic [XLEN-1:0]  ra_q;
  logic [XLEN-1:0]  rb_q;

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads, a write at the same edge is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (we_i && (waddr_i == ra_addr_i)) begin
        ra_q <= wdata_i;
      end else begin
        ra_q <= valid_q[ra_addr_i] ? mem[ra_addr_i] : '0;
      end
      if (we_i && (waddr_i == rb_addr_i)) begin
        rb_q <= wdata_i;
      end else begin
        rb_q <= valid_q[rb_addr_i] ? mem[rb_addr_i] : '0;
      end
    end
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

// ----- hdl/x86alu_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_exec
// Single-pass execute logic: adder, byte and 32-bit logic ops and the
// rotate/shift group, producing the register write and the new flags.
// ----------------------------------------------------------------------------
module x86alu_exec
  import x86alu_pkg::*;
(
  input  logic [FUNC_W-1:0] func_i,
  input  logic [RIDX_W-1:0] rm_i,
  input  logic [RIDX_W-1:0] rg_i,
  input  logic [XLEN-1:0]   imm_i,
  input  logic [XLEN-1:0]   a_i,
  input  logic [XLEN-1:0]   b_i,
  input  flags_t            flags_i,
  output exec_res_t         res_o
);

  logic [XLEN-1:0]   simm8;
  logic [XLEN-1:0]   opb;
  logic              is_sub;
  logic [XLEN:0]     sum;
  logic [XLEN-1:0]   ar;
  logic              ar_cf;
  logic              ar_of;
  logic [7:0]        a8;
  logic [7:0]        b8;
  logic [7:0]        and8;
  logic [7:0]        or8;
  logic [XLEN-1:0]   merged;
  logic [XLEN-1:0]   or32;
  logic [CNT_W-1:0]  cnt;
  logic [2*XLEN-1:0] dbl;
  logic [2*XLEN+1:0] dbl33;
  logic [2*XLEN-1:0] rol_w;
  logic [2*XLEN-1:0] ror_w;
  logic [2*XLEN+1:0] rcl_w;
  logic [2*XLEN+1:0] rcr_w;
  logic [XLEN:0]     shl_w;
  logic [XLEN:0]     shr_w;
  logic signed [XLEN:0] sar_w;
  logic [XLEN-1:0]   sh_r;
  logic              sh_cf;
  logic              sh_of;
  logic              sh_zs;
  exec_res_t         res;

  // adder shared by add, sub and cmp forms
  assign simm8  = {{(XLEN-8){imm_i[7]}}, imm_i[7:0]};
  assign is_sub = !((func_i == FUNC_ADD_I8) || (func_i == FUNC_ADD_RR));

  always_comb begin
    priority if ((func_i == FUNC_SUB_I32)) begin
      opb = imm_i;
    end else if ((func_i == FUNC_ADD_I8) || (func_i == FUNC_SUB_I8) ||
                 (func_i == FUNC_CMP_I8)) begin
      opb = simm8;
    end else begin
      opb = b_i;
    end
  end

  assign sum   = {1'b0, a_i} + {1'b0, (is_sub ? ~opb : opb)} + {{XLEN{1'b0}}, is_sub};
  assign ar    = sum[XLEN-1:0];
  assign ar_cf = is_sub ? ~sum[XLEN] : sum[XLEN];
  assign ar_of = is_sub ? ((a_i[XLEN-1] ^ opb[XLEN-1]) & (a_i[XLEN-1] ^ ar[XLEN-1]))
                        : (~(a_i[XLEN-1] ^ opb[XLEN-1]) & (a_i[XLEN-1] ^ ar[XLEN-1]));

  // byte register views: index bit 2 picks the high byte
  assign a8     = rm_i[2] ? a_i[15:8] : a_i[7:0];
  assign b8     = rg_i[2] ? b_i[15:8] : b_i[7:0];
  assign and8   = a8 & b8;
  assign or8    = a8 | imm_i[7:0];
  assign merged = rm_i[2] ? {a_i[XLEN-1:16], or8, a_i[7:0]} : {a_i[XLEN-1:8], or8};
  assign or32   = a_i | imm_i;

  // rotate and shift datapath, count in 0..31 (a zero count writes nothing)
  assign cnt   = imm_i[CNT_W-1:0];
  assign dbl   = {a_i, a_i};
  assign dbl33 = {flags_i.cf, a_i, flags_i.cf, a_i};
  assign rol_w = dbl >> (6'd32 - {1'b0, cnt});
  assign ror_w = dbl >> cnt;
  assign rcl_w = dbl33 >> (6'd33 - {1'b0, cnt});
  assign rcr_w = dbl33 >> cnt;
  assign shl_w = {1'b0, a_i} << cnt;
  assign shr_w = {a_i, 1'b0} >> cnt;
  assign sar_w = $signed({a_i, 1'b0}) >>> cnt;

  always_comb begin
    sh_r  = '0;
    sh_cf = flags_i.cf;
    sh_of = flags_i.of;
    sh_zs = 1'b0;
    unique case (rg_i)
      SH_ROL: begin
        sh_r  = rol_w[XLEN-1:0];
        sh_cf = sh_r[0];
        sh_of = sh_r[XLEN-1] ^ sh_r[0];
      end
      SH_ROR: begin
        sh_r  = ror_w[XLEN-1:0];
        sh_cf = sh_r[XLEN-1];
        sh_of = sh_r[XLEN-1] ^ sh_r[XLEN-2];
      end
      SH_RCL: begin
        sh_r  = rcl_w[XLEN-1:0];
        sh_cf = rcl_w[XLEN];
        sh_of = sh_r[XLEN-1] ^ rcl_w[XLEN];
      end
      SH_RCR: begin
        sh_r  = rcr_w[XLEN-1:0];
        sh_cf = rcr_w[XLEN];
        sh_of = sh_r[XLEN-1] ^ sh_r[XLEN-2];
      end
      SH_SHL, SH_SAL: begin
        sh_r  = shl_w[XLEN-1:0];
        sh_cf = shl_w[XLEN];
        sh_of = shl_w[XLEN-1] ^ shl_w[XLEN];
        sh_zs = 1'b1;
      end
      SH_SHR: begin
        sh_r  = shr_w[XLEN:1];
        sh_cf = shr_w[0];
        sh_of = a_i[XLEN-1];
        sh_zs = 1'b1;
      end
      SH_SAR: begin
        sh_r  = sar_w[XLEN:1];
        sh_cf = sar_w[0];
        sh_of = 1'b0;
        sh_zs = 1'b1;
      end
      default: begin
        sh_r = '0;
      end
    endcase
  end

  // operation select
  always_comb begin
    res       = '0;
    res.dst   = rm_i;
    res.flags = flags_i;
    unique case (func_i)
      FUNC_CMP_RR, FUNC_CMP_I8: begin
        res.flags = '{cf: ar_cf, zf: (ar == '0), sf: ar[XLEN-1], of: ar_of};
      end
      FUNC_SUB_I32, FUNC_ADD_I8, FUNC_SUB_I8, FUNC_ADD_RR, FUNC_SUB_RR: begin
        res.wr    = 1'b1;
        res.value = ar;
        res.flags = '{cf: ar_cf, zf: (ar == '0), sf: ar[XLEN-1], of: ar_of};
      end
      FUNC_TEST_R8: begin
        res.flags = '{cf: 1'b0, zf: (and8 == '0), sf: and8[7], of: 1'b0};
      end
      FUNC_OR_R8_I8: begin
        res.wr    = 1'b1;
        res.dst   = {1'b0, rm_i[1:0]};
        res.value = merged;
        res.flags = '{cf: 1'b0, zf: (or8 == '0), sf: or8[7], of: 1'b0};
      end
      FUNC_OR_EAX, FUNC_OR_I32: begin
        res.wr    = 1'b1;
        res.dst   = (func_i == FUNC_OR_EAX) ? '0 : rm_i;
        res.value = or32;
        res.flags = '{cf: 1'b0, zf: (or32 == '0), sf: or32[XLEN-1], of: 1'b0};
      end
      FUNC_SHIFT: begin
        // a zero count leaves state untouched
        if (cnt != '0) begin
          res.wr       = 1'b1;
          res.value    = sh_r;
          res.flags.cf = sh_cf;
          res.flags.of = sh_of;
          if (sh_zs) begin
            res.flags.zf = (sh_r == '0);
            res.flags.sf = sh_r[XLEN-1];
          end
        end
      end
      default: begin
        res.wr = 1'b0;
      end
    endcase
    // no register written: report index and value as zero
    if (!res.wr) begin
      res.dst   = '0;
      res.value = '0;
    end
  end

  assign res_o = res;

endmodule

// ----- hdl/x86_alu_register_ops.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_alu_register_ops
// Register-form 32-bit x86 ALU subset on an eight-entry register file with
// carry, zero, sign and overflow flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one instruction per item:
//   func, modrm and immediate. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result item per instruction: destination index and
//   value, the write indication and the four flags after the instruction.
//   An accepted item loads the operand register and the register-file read
//   data, then moves into the result register that drives the outputs.
//   Throughput: one item per cycle while the receiver does not stall. The
//   register file is read when an item is taken in, with the write of the
//   instruction ahead forwarded; registers and flags update as the item
//   enters the result register, so dependent instructions issue back to back.
//   Reset clears the register file (through per-entry valid bits), the flags
//   and both valid stages; the block is ready right after reset.
//   When the receiver stalls, the result register holds; one more item can
//   wait in the operand stage, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module x86_alu_register_ops
  import x86alu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [7:0]        modrm_i,
  input  logic [XLEN-1:0]   immediate_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RIDX_W-1:0] dest_index_o,
  output logic [XLEN-1:0]   dest_value_o,
  output logic              wrote_o,
  output logic              carry_out_o,
  output logic              zero_out_o,
  output logic              sign_out_o,
  output logic              overflow_out_o
);

  logic              accept;
  logic              advance;
  logic              op_valid_q;
  logic              op_valid_d;
  logic [FUNC_W-1:0] func_q;
  logic [RIDX_W-1:0] rm_q;
  logic [RIDX_W-1:0] rg_q;
  logic [XLEN-1:0]   imm_q;
  logic [RIDX_W-1:0] ra_addr;
  logic [RIDX_W-1:0] rb_addr;
  logic [XLEN-1:0]   ra_data;
  logic [XLEN-1:0]   rb_data;
  flags_t            flags_q;
  exec_res_t         res;
  logic              out_valid_q;
  logic              out_valid_d;
  exec_res_t         out_q;

  // handshake: operand stage moves on when the result register is free
  assign advance    = op_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !op_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign op_valid_d = accept || (op_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  // read addresses from the incoming item
  always_comb begin
    priority if (func_i == FUNC_OR_EAX) begin
      ra_addr = '0;
    end else if ((func_i == FUNC_TEST_R8) || (func_i == FUNC_OR_R8_I8)) begin
      ra_addr = {1'b0, modrm_i[1:0]};
    end else begin
      ra_addr = modrm_i[2:0];
    end
    rb_addr = (func_i == FUNC_TEST_R8) ? {1'b0, modrm_i[4:3]} : modrm_i[5:3];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      op_valid_q  <= op_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= res.flags;
      end
    end
  end

  // operand stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      rm_q   <= modrm_i[2:0];
      rg_q   <= modrm_i[5:3];
      imm_q  <= immediate_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  x86alu_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .we_i      (advance && res.wr),
    .waddr_i   (res.dst),
    .wdata_i   (res.value),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  x86alu_exec u_exec (
    .func_i  (func_q),
    .rm_i    (rm_q),
    .rg_i    (rg_q),
    .imm_i   (imm_q),
    .a_i     (ra_data),
    .b_i     (rb_data),
    .flags_i (flags_q),
    .res_o   (res)
  );

  assign out_valid_o    = out_valid_q;
  assign dest_index_o   = out_q.dst;
  assign dest_value_o   = out_q.value;
  assign wrote_o        = out_q.wr;
  assign carry_out_o    = out_q.flags.cf;
  assign zero_out_o     = out_q.flags.zf;
  assign sign_out_o     = out_q.flags.sf;
  assign overflow_out_o = out_q.flags.of;

`ifndef SYNTH
  // no write reported means index and value read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wrote_o |-> (dest_index_o == '0) && (dest_value_o == '0))
    else $error("result without write carries nonzero index or value");

  // input side stalls only when both stages are full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> op_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // a new result only appears after an item left the operand stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(advance))
    else $error("result appeared without an executed item");

  // flags shown on the outputs are the committed architectural flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (flags_q == out_q.flags))
    else $error("committed flags differ from reported flags");
`endif

endmodule
